/* hw/rtl/bcf_pkg.sv */
`timescale 1ns / 1ps
// Shared constants for the Bezier curve flattener.
// No dependencies; bezier_curve_flattener_unit imports this package.
package bcf_pkg;
   localparam int MaxSegDefault     = 64;
   localparam int CoordWidthDefault = 16;
   localparam int SegCountWidth     = 7;
   localparam int VertexWidth       = 16;
   localparam logic [SegCountWidth-1:0] SegCountReset = 7'd64;
endpackage

/* hw/rtl/bcf_req_if.sv */
`timescale 1ns / 1ps
// Request channel of the Bezier curve flattener: one curve per request.
// Depends on nothing; the coordinate width is a parameter.
interface bcf_req_if #(parameter int CW = 16);
   logic                 valid;
   logic                 ready;
   logic                 action;
   logic signed [CW-1:0] start_x;
   logic signed [CW-1:0] start_y;
   logic signed [CW-1:0] ctrl_a_x;
   logic signed [CW-1:0] ctrl_a_y;
   logic signed [CW-1:0] ctrl_b_x;
   logic signed [CW-1:0] ctrl_b_y;
   logic signed [CW-1:0] finish_x;
   logic signed [CW-1:0] finish_y;

   modport source (output valid, action, start_x, start_y, ctrl_a_x, ctrl_a_y,
                   ctrl_b_x, ctrl_b_y, finish_x, finish_y, input ready);
   modport sink (input valid, action, start_x, start_y, ctrl_a_x, ctrl_a_y,
                 ctrl_b_x, ctrl_b_y, finish_x, finish_y, output ready);
endinterface

/* hw/rtl/bcf_rsp_if.sv */
`timescale 1ns / 1ps
// Response channel of the Bezier curve flattener: one line segment per response.
// Depends on nothing; the coordinate width is a parameter.
interface bcf_rsp_if #(parameter int CW = 16);
   logic                 valid;
   logic                 ready;
   logic signed [CW-1:0] seg_start_x;
   logic signed [CW-1:0] seg_start_y;
   logic signed [CW-1:0] seg_end_x;
   logic signed [CW-1:0] seg_end_y;
   logic [15:0]          first_vertex;
   logic                 last_segment;

   modport source (output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                   first_vertex, last_segment, input ready);
   modport sink (input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                 first_vertex, last_segment, output ready);
endinterface

/* hw/rtl/bezier_curve_flattener_unit.sv */
`timescale 1ns / 1ps
// Top level of the Bezier curve flattener: sequencer around one shared multiplier
// and one bit-serial divider. Uses bcf_pkg, bcf_req_if and bcf_rsp_if.
//
//   channel  direction  carries
//   req_if   in         curve kind and four control points (one curve)
//   rsp_if   out        one line segment, its first vertex index, last flag
//   csr_*    in         segment count N, write only
//
// Per curve: form the divisor, then per segment the Bernstein weights, and for
// each of x and y a multiply/accumulate pass and a division; the segment then
// waits in the output register until it is taken.
// The divider is restoring and yields one quotient bit per cycle.
// req_if.ready is high only while no curve is in work. A stalled response
// holds the sequencer; reset is synchronous and restores N = 64 and vertex 0.
module bezier_curve_flattener_unit #(
   parameter int MAX_SEGMENTS = bcf_pkg::MaxSegDefault,
   parameter int COORD_WIDTH  = bcf_pkg::CoordWidthDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   bcf_req_if.sink                          req_if,
   bcf_rsp_if.source                        rsp_if,
   input  logic                             csr_we,
   input  logic [bcf_pkg::SegCountWidth-1:0] csr_wdata
);
   import bcf_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int KW = $clog2(MAX_SEGMENTS + 1);
   // Every Bernstein weight and the divisor stay at or below N cubed.
   localparam int DW = $clog2(MAX_SEGMENTS * MAX_SEGMENTS * MAX_SEGMENTS + 1);
   localparam int PW = DW + CW + 1;
   localparam int NW = $clog2(CW);

   typedef enum logic [2:0] {
      ST_IDLE, ST_PREP, ST_WGT, ST_MUL, ST_DIV, ST_OUT
   } state_type;

   state_type               state_ff;
   logic [2:0]              step_ff;
   logic [NW-1:0]           div_cnt_ff;
   logic                    axis_ff;
   logic [SegCountWidth-1:0] seg_count_ff;
   logic [VertexWidth-1:0]  vertex_ff;
   logic                    cubic_ff;
   logic signed [CW-1:0]    cx_ff [4];
   logic signed [CW-1:0]    cy_ff [4];
   logic [KW-1:0]           n_ff;
   logic [KW-1:0]           k_ff;
   logic [DW-1:0]           nn_ff;
   logic [DW-1:0]           den_ff;
   logic [DW-1:0]           t1_ff, t2_ff, t3_ff;
   logic [DW-1:0]           u0_ff, u1_ff, u2_ff, u3_ff;
   logic [DW-1:0]           w_ff [4];
   logic signed [PW-1:0]    prod_ff;
   logic signed [PW-1:0]    acc_ff;
   logic [DW-1:0]           rem_ff;
   logic [CW-1:0]           quo_ff;
   logic signed [CW-1:0]    sx_ff, sy_ff, ex_ff, ey_ff;
   logic                    last_ff;
   logic                    rsp_valid_ff;

   logic [KW-1:0]           n_clamp;
   logic [KW-1:0]           m_val;
   logic [DW-1:0]           m_u, k_u, n_u;
   logic signed [CW-1:0]    m_s, k_s, n_s;
   logic [DW-1:0]           mul_a;
   logic signed [CW-1:0]    mul_b;
   logic signed [PW-1:0]    mul_p;
   logic signed [PW-1:0]    acc_sum;
   logic [DW:0]             trial;
   logic [DW:0]             diff;
   logic                    trial_ge;
   logic [DW-1:0]           rem_next;
   logic [CW-1:0]           quo_next;
   logic [CW-1:0]           coord_q;
   logic                    req_take;
   logic                    rsp_take;

   // A count of zero means one segment; counts above the maximum saturate.
   always_comb begin
      if (seg_count_ff == '0) begin
         n_clamp = KW'(1);
      end else if (seg_count_ff > SegCountWidth'(MAX_SEGMENTS)) begin
         n_clamp = KW'(MAX_SEGMENTS);
      end else begin
         n_clamp = seg_count_ff[KW-1:0];
      end
   end

   assign m_val = n_ff - k_ff;
   assign m_u   = {{(DW-KW){1'b0}}, m_val};
   assign k_u   = {{(DW-KW){1'b0}}, k_ff};
   assign n_u   = {{(DW-KW){1'b0}}, n_ff};
   assign m_s   = {{(CW-KW){1'b0}}, m_val};
   assign k_s   = {{(CW-KW){1'b0}}, k_ff};
   assign n_s   = {{(CW-KW){1'b0}}, n_ff};

   // Operand selection for the one shared multiplier. The weight steps form
   // m^2, mk, k^2, m^3, m^2 k, m k^2 and k^3 in turn.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_PREP: begin
            mul_a = step_ff[0] ? nn_ff : n_u;
            mul_b = n_s;
         end
         ST_WGT: begin
            case (step_ff)
               3'd0: begin mul_a = m_u;   mul_b = m_s; end
               3'd1: begin mul_a = m_u;   mul_b = k_s; end
               3'd2: begin mul_a = k_u;   mul_b = k_s; end
               3'd3: begin mul_a = t1_ff; mul_b = m_s; end
               3'd4: begin mul_a = t1_ff; mul_b = k_s; end
               3'd5: begin mul_a = t3_ff; mul_b = m_s; end
               3'd6: begin mul_a = t3_ff; mul_b = k_s; end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         ST_MUL: begin
            mul_a = w_ff[step_ff[1:0]];
            mul_b = axis_ff ? cy_ff[step_ff[1:0]] : cx_ff[step_ff[1:0]];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p   = $signed({1'b0, mul_a}) * mul_b;
   assign acc_sum = acc_ff + prod_ff;

   // Restoring division, one quotient bit per cycle. The accumulator carries a
   // bias of D * 2^(CW-1), so the dividend is never negative and the unsigned
   // quotient is the floor quotient with its sign bit flipped.
   assign trial    = {rem_ff, quo_ff[CW-1]};
   assign diff     = trial - {1'b0, den_ff};
   assign trial_ge = (trial >= {1'b0, den_ff});
   assign rem_next = trial_ge ? diff[DW-1:0] : trial[DW-1:0];
   assign quo_next = {quo_ff[CW-2:0], trial_ge};
   assign coord_q  = {~quo_next[CW-1], quo_next[CW-2:0]};

   assign req_take = req_if.valid && req_if.ready;
   assign rsp_take = rsp_valid_ff && rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         div_cnt_ff   <= '0;
         axis_ff      <= 1'b0;
         seg_count_ff <= SegCountReset;
         vertex_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            seg_count_ff <= csr_wdata;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  cubic_ff <= req_if.action;
                  cx_ff[0] <= req_if.start_x;
                  cy_ff[0] <= req_if.start_y;
                  cx_ff[1] <= req_if.ctrl_a_x;
                  cy_ff[1] <= req_if.ctrl_a_y;
                  cx_ff[2] <= req_if.ctrl_b_x;
                  cy_ff[2] <= req_if.ctrl_b_y;
                  cx_ff[3] <= req_if.finish_x;
                  cy_ff[3] <= req_if.finish_y;
                  sx_ff    <= req_if.start_x;
                  sy_ff    <= req_if.start_y;
                  n_ff     <= n_clamp;
                  k_ff     <= KW'(1);
                  step_ff  <= '0;
                  state_ff <= ST_PREP;
               end
            end
            ST_PREP: begin
               // Divisor is N squared for a quadratic curve, N cubed for a cubic.
               if (step_ff[0] == 1'b0) begin
                  nn_ff   <= mul_p[DW-1:0];
                  step_ff <= 3'd1;
               end else begin
                  den_ff   <= cubic_ff ? mul_p[DW-1:0] : nn_ff;
                  step_ff  <= '0;
                  state_ff <= ST_WGT;
               end
            end
            ST_WGT: begin
               case (step_ff)
                  3'd0: t1_ff <= mul_p[DW-1:0];
                  3'd1: t2_ff <= mul_p[DW-1:0];
                  3'd2: t3_ff <= mul_p[DW-1:0];
                  3'd3: u0_ff <= mul_p[DW-1:0];
                  3'd4: u1_ff <= mul_p[DW-1:0];
                  3'd5: u2_ff <= mul_p[DW-1:0];
                  3'd6: u3_ff <= mul_p[DW-1:0];
                  default: begin
                     // The quadratic form uses m^2, 2mk and k^2; its third
                     // weight is zero so the second control point drops out.
                     w_ff[0] <= cubic_ff ? u0_ff : t1_ff;
                     w_ff[1] <= cubic_ff ? (u1_ff + DW'({u1_ff, 1'b0}))
                                         : DW'({t2_ff, 1'b0});
                     w_ff[2] <= cubic_ff ? (u2_ff + DW'({u2_ff, 1'b0})) : '0;
                     w_ff[3] <= cubic_ff ? u3_ff : t3_ff;
                     axis_ff <= 1'b0;
                  end
               endcase
               step_ff <= step_ff + 3'd1;
               if (step_ff == 3'd7) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               // Products are registered and summed in the following cycle.
               prod_ff <= mul_p;
               if (step_ff == 3'd0) begin
                  acc_ff <= $signed({{(CW+1){1'b0}}, den_ff}) <<< (CW - 1);
               end else begin
                  acc_ff <= acc_sum;
               end
               if (step_ff == 3'd4) begin
                  rem_ff     <= acc_sum[CW+DW-1:CW];
                  quo_ff     <= acc_sum[CW-1:0];
                  div_cnt_ff <= NW'(CW - 1);
                  step_ff    <= '0;
                  state_ff   <= ST_DIV;
               end else begin
                  step_ff <= step_ff + 3'd1;
               end
            end
            ST_DIV: begin
               rem_ff     <= rem_next;
               quo_ff     <= quo_next;
               div_cnt_ff <= div_cnt_ff - NW'(1);
               if (div_cnt_ff == '0) begin
                  if (!axis_ff) begin
                     ex_ff    <= coord_q;
                     axis_ff  <= 1'b1;
                     state_ff <= ST_MUL;
                  end else begin
                     ey_ff        <= coord_q;
                     last_ff      <= (k_ff == n_ff);
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_OUT;
                  end
               end
            end
            ST_OUT: begin
               if (rsp_take) begin
                  rsp_valid_ff <= 1'b0;
                  sx_ff        <= ex_ff;
                  sy_ff        <= ey_ff;
                  vertex_ff    <= vertex_ff + VertexWidth'(2);
                  step_ff      <= '0;
                  if (last_ff) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     k_ff     <= k_ff + KW'(1);
                     state_ff <= ST_WGT;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_if.ready        = (state_ff == ST_IDLE);
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.seg_start_x  = sx_ff;
   assign rsp_if.seg_start_y  = sy_ff;
   assign rsp_if.seg_end_x    = ex_ff;
   assign rsp_if.seg_end_y    = ey_ff;
   assign rsp_if.first_vertex = vertex_ff;
   assign rsp_if.last_segment = last_ff;
endmodule

/* hw/rtl/bcf_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the Bezier curve flattener and their bind statement.
// Depends on bezier_curve_flattener_unit and its channel interfaces.
module bcf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last
);
   // A waiting segment stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // No new curve is taken while a segment is on offer.
   a_busy_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request ready while a response is pending");

   // A new curve never produces a segment in the very next cycle.
   a_req_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("response too soon after request");

   // The block stays busy until the last segment has gone out.
   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> !req_ready)
      else $error("request ready before the curve is finished");

   // After the last segment the block is free again.
   a_end_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready)
      else $error("block not ready after the last segment");
endmodule

bind bezier_curve_flattener_unit bcf_checker u_bcf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_last  (rsp_if.last_segment)
);
